### sv/multilevel_feedback_queue_scheduler_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the multilevel feedback queue scheduler
// Concurrent assertion wrappers on one clock form; only one is disabled in reset.
// ---------------------------------------------------------------------------
`ifndef MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_ASSERT_SVH

// Check a property while reset is released
`define MFQS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mfqs assertion failed");

// Check a property at every edge, reset included
`define MFQS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("mfqs assertion failed");

`endif

### sv/mfqs_pkg.sv
// ---------------------------------------------------------------------------
// Scheduler package
// Field widths, command and status codes, and helpers shared by the block.
// ---------------------------------------------------------------------------
package mfqs_pkg;

    localparam int ID_W       = 22;
    localparam int LVL_W      = 2;
    localparam int CMD_W      = 2;
    localparam int STAT_W     = 2;
    localparam int NUM_LEVELS = 4;
    localparam int DATA_W     = 24;   // proc_id + level, whole bytes

    typedef enum logic [CMD_W-1:0] {
        CMD_ADMIT    = 2'd0,
        CMD_DISPATCH = 2'd1,
        CMD_REQUEUE  = 2'd2
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Result description carried from the queue stage to the output stage
    typedef struct packed {
        logic                 from_ram;
        logic [ID_W-1:0]      id;
        logic [LVL_W-1:0]     lvl;
        status_t              status;
    } res_meta_t;

    // Demote one level, keeping the top and bottom levels in place
    function automatic logic [LVL_W-1:0] demote(input logic [LVL_W-1:0] lvl);
        logic [LVL_W-1:0] res;
        if (lvl == '0 || lvl == LVL_W'(NUM_LEVELS - 1)) begin
            res = lvl;
        end else begin
            res = lvl + LVL_W'(1);
        end
        return res;
    endfunction

endpackage

### sv/mfqs_ram.sv
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module mfqs_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read; read data holds when no read is issued
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/multilevel_feedback_queue_scheduler.sv
// ---------------------------------------------------------------------------
// Multilevel feedback queue scheduler
// Four circular queues of process identifiers, one per priority level,
// with admit, dispatch and requeue-with-demotion commands.
// ---------------------------------------------------------------------------
//  Channel | Dir | tdata (low bit up)              | tuser
//  s_      | in  | proc_id[21:0], level[23:22]     | command[1:0]
//  m_      | out | result_id[21:0], result_lvl[23:22] | status[1:0]
//
//  One command per cycle while the output is not stalled.
//  The queue stage updates pointers and the queue RAM; the RAM read port
//  (registered read) and the output register carry each result to m_.
//  Reset clears all pointers and counts at once; s_tready is low in reset.
//  A stalled output holds its result; one more command is taken into the
//  queue stage before the input stalls.
// ---------------------------------------------------------------------------
module multilevel_feedback_queue_scheduler #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input command channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mfqs_pkg::DATA_W-1:0]   s_tdata,   // proc_id, level
    input  logic [mfqs_pkg::CMD_W-1:0]    s_tuser,   // command
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mfqs_pkg::DATA_W-1:0]   m_tdata,   // result_id, result_level
    output logic [mfqs_pkg::STAT_W-1:0]   m_tuser    // status
);

    import mfqs_pkg::*;

    localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W = LVL_W + IDX_W;
    localparam int RAM_D  = NUM_LEVELS << IDX_W;

    // Per-level pointers and occupancy
    logic [IDX_W-1:0] head_reg [NUM_LEVELS];
    logic [IDX_W-1:0] tail_reg [NUM_LEVELS];
    logic [CNT_W-1:0] count_reg [NUM_LEVELS];

    // Queue stage and output stage
    logic      a_valid_reg, a_valid_next;
    res_meta_t a_meta_reg,  a_meta_next;
    logic      b_valid_reg;
    res_meta_t b_meta_reg;
    logic [ID_W-1:0] b_id_reg;

    logic [ID_W-1:0]  in_id;
    logic [LVL_W-1:0] in_lvl;
    logic [LVL_W-1:0] target;
    logic [LVL_W-1:0] pick;
    logic             any_busy;
    logic             target_full;
    logic             accept;
    logic             a_go;
    logic             do_push;
    logic             do_pop;
    logic [ID_W-1:0]  ram_rdata;

    assign in_id  = s_tdata[ID_W-1:0];
    assign in_lvl = s_tdata[ID_W +: LVL_W];

    // Handshake between the stages; refuse input while in reset
    assign a_go     = a_valid_reg && (!b_valid_reg || m_tready);
    assign s_tready = aresetn && (!a_valid_reg || a_go);
    assign accept   = s_tvalid && s_tready;

    // Pick the highest-priority non-empty level
    always_comb begin
        pick     = '0;
        any_busy = 1'b0;
        for (int k = NUM_LEVELS - 1; k >= 0; k--) begin
            if (count_reg[k] != '0) begin
                pick     = LVL_W'(k);
                any_busy = 1'b1;
            end
        end
    end

    // Decode the command and form the result description
    always_comb begin
        target      = (s_tuser == CMD_REQUEUE) ? demote(in_lvl) : in_lvl;
        target_full = (count_reg[target] == CNT_W'(QUEUE_DEPTH));
        do_push     = 1'b0;
        do_pop      = 1'b0;
        a_meta_next = '{from_ram: 1'b0, id: '0, lvl: '0, status: ST_OK};
        case (s_tuser)
            CMD_ADMIT, CMD_REQUEUE: begin
                do_push            = accept && !target_full;
                a_meta_next.id     = in_id;
                a_meta_next.lvl    = target;
                a_meta_next.status = target_full ? ST_FULL : ST_OK;
            end
            CMD_DISPATCH: begin
                do_pop = accept && any_busy;
                if (any_busy) begin
                    a_meta_next.from_ram = 1'b1;
                    a_meta_next.lvl      = pick;
                end else begin
                    a_meta_next.status = ST_EMPTY;
                end
            end
            default: begin
                a_meta_next = '{from_ram: 1'b0, id: '0, lvl: '0, status: ST_OK};
            end
        endcase
        a_valid_next = accept || (a_valid_reg && !a_go);
    end

    // Advance queue pointers and counts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_LEVELS; k++) begin
                head_reg[k]  <= '0;
                tail_reg[k]  <= '0;
                count_reg[k] <= '0;
            end
        end else begin
            if (do_push) begin
                tail_reg[target]  <= (tail_reg[target] == IDX_W'(QUEUE_DEPTH - 1))
                                     ? '0 : tail_reg[target] + IDX_W'(1);
                count_reg[target] <= count_reg[target] + CNT_W'(1);
            end
            if (do_pop) begin
                head_reg[pick]  <= (head_reg[pick] == IDX_W'(QUEUE_DEPTH - 1))
                                   ? '0 : head_reg[pick] + IDX_W'(1);
                count_reg[pick] <= count_reg[pick] - CNT_W'(1);
            end
        end
    end

    // Queue storage, all levels in one RAM addressed by {level, index}
    mfqs_ram #(
        .WIDTH (ID_W),
        .DEPTH (RAM_D)
    ) u_ram (
        .clk   (aclk),
        .we    (do_push),
        .waddr (ADDR_W'({target, tail_reg[target]})),
        .wdata (in_id),
        .re    (do_pop),
        .raddr (ADDR_W'({pick, head_reg[pick]})),
        .rdata (ram_rdata)
    );

    // Queue stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_meta_reg <= a_meta_next;
        end
    end

    // Output register: load from the queue stage, drop on transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (a_go) begin
            b_valid_reg <= 1'b1;
        end else if (m_tready) begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_go) begin
            b_meta_reg <= a_meta_reg;
            b_id_reg   <= a_meta_reg.from_ram ? ram_rdata : a_meta_reg.id;
        end
    end

    assign m_tvalid = b_valid_reg;
    assign m_tdata  = {b_meta_reg.lvl, b_id_reg};
    assign m_tuser  = b_meta_reg.status;

endmodule

### sv/mfqs_chk.sv
// ---------------------------------------------------------------------------
// Scheduler port checker
// Watches the input handshake and result channel of the scheduler and is bound to its top level.
// ---------------------------------------------------------------------------
`include "multilevel_feedback_queue_scheduler_assert.svh"

module mfqs_chk (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [mfqs_pkg::DATA_W-1:0] m_tdata,
    input logic [mfqs_pkg::STAT_W-1:0] m_tuser
);

    import mfqs_pkg::*;

    // Stalled result holds its payload
    `MFQS_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // No result comes out of reset
    `MFQS_ASSERT_ALWAYS(a_rst, aclk, !aresetn |=> !m_tvalid)

    // An empty dispatch carries no identifier and level
    `MFQS_ASSERT(a_empty, aclk, aresetn, m_tvalid && m_tuser == ST_EMPTY |-> m_tdata == '0)

    // Status is always a defined code
    `MFQS_ASSERT(a_stat, aclk, aresetn, m_tvalid |-> m_tuser == ST_OK || m_tuser == ST_EMPTY || m_tuser == ST_FULL)

    // With the output free the input is never refused
    `MFQS_ASSERT(a_ready, aclk, aresetn, !m_tvalid |-> s_tready || !s_tvalid || $past(s_tvalid && s_tready))

endmodule

bind multilevel_feedback_queue_scheduler mfqs_chk u_mfqs_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
